/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the packer checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge; skipped while reset is high.
`define RSP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on the rising clock edge, including during reset.
`define RSP_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rsp_pkg.sv */
// ----------------------------------------------------------------------------
// rsp_pkg
// Types and constants shared by the radix symbol packer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rsp_pkg;

  // Field widths fixed by the interface
  localparam int SYMBOL_W  = 8;
  localparam int RADIX_W   = 4;
  localparam int PERWORD_W = 5;
  localparam int OUTWORD_W = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  // Word-length compare width: holds any field value and any word length up to 32
  localparam int LEN_W     = 6;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYMBOL_COUNT     = 2'd0,
    REG_SYMBOLS_PER_WORD = 2'd1,
    REG_ALPHABET_CODES   = 2'd2
  } rsp_reg_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_PAD,
    ST_EMIT
  } rsp_state_t;

  // Input item
  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
  } rsp_in_t;

  // Result item
  typedef struct packed {
    logic [OUTWORD_W-1:0] packed_word;
    logic [PERWORD_W-1:0] symbols_filled;
    logic                 final_word;
  } rsp_out_t;

endpackage

`default_nettype wire

/* rtl/rsp_rank_lookup.sv */
// ----------------------------------------------------------------------------
// rsp_rank_lookup
// Maps a symbol byte to its rank in the configured alphabet; misses give 0.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_rank_lookup
  import rsp_pkg::*;
#(
  parameter int MAX_SYMBOLS = 8,
  parameter int RANK_W      = 3
) (
  input  wire logic [SYMBOL_W-1:0]             symbol,
  input  wire logic [MAX_SYMBOLS*SYMBOL_W-1:0] codes,
  input  wire logic [RADIX_W-1:0]              count,
  output logic      [RANK_W-1:0]               rank
);

  // Search from the top entry down so the lowest matching rank wins
  always_comb begin
    rank = '0;
    for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
      if ((RADIX_W'(k) < count) && (codes[k*SYMBOL_W +: SYMBOL_W] == symbol)) begin
        rank = RANK_W'(k);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/rsp_serial_mult.sv */
// ----------------------------------------------------------------------------
// rsp_serial_mult
// Shift-add multiply-accumulate, one radix bit per cycle:
// result = operand * radix + addend, modulo 2^WORD_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_serial_mult
  import rsp_pkg::*;
#(
  parameter int WORD_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [WORD_BITS-1:0] operand,
  input  wire logic [RADIX_W-1:0]   radix,
  input  wire logic [WORD_BITS-1:0] addend,
  output logic                      done,
  output logic      [WORD_BITS-1:0] result
);

  localparam int STEP_W = $clog2(RADIX_W);

  logic                 active;
  logic [STEP_W-1:0]    step;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] mcand;
  logic [RADIX_W-1:0]   mplier;

  // Sequence control: run RADIX_W steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + 1'b1;
        if (step == STEP_W'(RADIX_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the shifted multiplicand for each set radix bit, LSB first
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= addend;
      mcand  <= operand;
      mplier <= radix;
    end else if (active) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign result = acc;

endmodule

`default_nettype wire

/* rtl/radix_symbol_packer.sv */
// ----------------------------------------------------------------------------
// radix_symbol_packer
// Packs symbol bytes into mixed-radix words, first symbol most significant.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries one symbol byte and a last flag; a transfer happens when
//   in_valid and in_ready are both high. Each symbol's rank in the alphabet
//   is folded into the word as word * symbol_count + rank. out_data carries a
//   packed word once symbols_per_word symbols are in, or at the symbol marked
//   last, where empty positions are padded with rank 0 first.
//   Timing: the radix multiply runs on a shift-add unit, one radix bit per
//   cycle, and in_ready stays low from a transfer until its multiply is done.
//   Each padding position adds another multiply, and a completed word then
//   loads the output register before the input is freed.
//   The output register holds a result until out_ready; while it is taken the
//   next symbols are still accepted, and only loading the following word
//   waits for the register to empty.
//   Reset (rst, synchronous) clears the partial word and the output valid flag
//   and sets symbol_count and symbols_per_word to 4, alphabet_codes to 0.
//   Configuration writes (cfg_write, cfg_index, cfg_data) land at once; the user
//   must make them only while the block is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_symbol_packer
  import rsp_pkg::*;
#(
  parameter int WORD_BITS    = 16,
  parameter int MAX_SYMBOLS  = 8,
  parameter int MAX_PER_WORD = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write port
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // Symbol input
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rsp_in_t              in_data,
  // Packed word output
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rsp_out_t                  out_data
);

  localparam int RANK_W = $clog2(MAX_SYMBOLS);
  localparam int CODES_W = MAX_SYMBOLS * SYMBOL_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PER_WORD);

  // Configuration registers
  logic [RADIX_W-1:0]   symbol_count;
  logic [PERWORD_W-1:0] symbols_per_word;
  logic [CODES_W-1:0]   alphabet_codes;

  // Word state
  rsp_state_t           state;
  rsp_state_t           state_next;
  logic [WORD_BITS-1:0] partial_word;
  logic [PERWORD_W-1:0] fill_count;
  logic                 last_flag;
  logic [LEN_W-1:0]     pad_left;

  // Sequencer outputs and status
  logic                 mul_start;
  logic                 mul_done;
  logic [WORD_BITS-1:0] mul_result;
  logic [WORD_BITS-1:0] mul_operand;
  logic [WORD_BITS-1:0] mul_addend;
  logic [RANK_W-1:0]    rank;
  logic [LEN_W-1:0]     word_len;
  logic                 word_full;
  logic                 pad_last;
  logic                 emit_load;
  logic [WORD_BITS+OUTWORD_W-1:0] word_ext;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count     <= RADIX_W'(4);
      symbols_per_word <= PERWORD_W'(4);
      alphabet_codes   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SYMBOL_COUNT:     symbol_count     <= cfg_data[RADIX_W-1:0];
        REG_SYMBOLS_PER_WORD: symbols_per_word <= cfg_data[PERWORD_W-1:0];
        REG_ALPHABET_CODES:   alphabet_codes   <= cfg_data[CODES_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the word length to 1..MAX_PER_WORD
  always_comb begin
    if (symbols_per_word == '0) begin
      word_len = LEN_W'(1);
    end else if (LEN_W'(symbols_per_word) > MAX_LEN) begin
      word_len = MAX_LEN;
    end else begin
      word_len = LEN_W'(symbols_per_word);
    end
  end

  assign word_full = LEN_W'(fill_count) >= word_len;
  assign pad_last  = pad_left == LEN_W'(1);

  rsp_rank_lookup #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .RANK_W      (RANK_W)
  ) u_rank (
    .symbol (in_data.symbol),
    .codes  (alphabet_codes),
    .count  (symbol_count),
    .rank   (rank)
  );

  rsp_serial_mult #(
    .WORD_BITS (WORD_BITS)
  ) u_mult (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .operand (mul_operand),
    .radix   (symbol_count),
    .addend  (mul_addend),
    .done    (mul_done),
    .result  (mul_result)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          if (word_full)      state_next = ST_EMIT;
          else if (last_flag) state_next = ST_PAD;
          else                state_next = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (mul_done && pad_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    mul_start   = 1'b0;
    mul_operand = mul_result;
    mul_addend  = '0;
    emit_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        mul_start   = in_valid;
        mul_operand = partial_word;
        mul_addend  = WORD_BITS'(rank);
      end
      ST_MUL:  mul_start = mul_done && !word_full && last_flag;
      ST_PAD:  mul_start = mul_done && !pad_last;
      ST_EMIT: emit_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Advance the partial word, fill count and padding counter
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_word <= '0;
      fill_count   <= '0;
      last_flag    <= 1'b0;
      pad_left     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        fill_count <= fill_count + 1'b1;
        last_flag  <= in_data.last;
      end
      if (mul_done) begin
        partial_word <= mul_result;
      end
      if (state == ST_MUL && mul_done) begin
        pad_left <= word_len - LEN_W'(fill_count);
      end else if (state == ST_PAD && mul_done) begin
        pad_left <= pad_left - 1'b1;
      end
      if (emit_load) begin
        partial_word <= '0;
        fill_count   <= '0;
      end
    end
  end

  // Low output bits of the word, zero-extended for narrow words
  assign word_ext = {{OUTWORD_W{1'b0}}, partial_word};

  // Output register: load a finished word, drop valid after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data.packed_word    <= word_ext[OUTWORD_W-1:0];
      out_data.symbols_filled <= fill_count;
      out_data.final_word     <= last_flag;
    end
  end

endmodule

`default_nettype wire

/* rtl/rsp_checker.sv */
// ----------------------------------------------------------------------------
// rsp_checker
// Port-level checks on the radix symbol packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rsp_checker
  import rsp_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire rsp_out_t out_data
);

  // Reset leaves the output empty and the input open
  `RSP_ASSERT_RST(a_reset_clears, clk, rst |=> (!out_valid && in_ready), "reset did not clear")

  // A stalled result holds its value
  `RSP_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "stalled result changed")

  // One symbol at a time: the input closes after each transfer
  `RSP_ASSERT(a_one_at_a_time, clk, rst, (in_valid && in_ready) |=> !in_ready, "input open during multiply")

  // A word always holds at least one real symbol
  `RSP_ASSERT(a_filled_nonzero, clk, rst, out_valid |-> (out_data.symbols_filled != '0), "empty word emitted")

endmodule

bind radix_symbol_packer rsp_checker u_rsp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
